FILE: src/bitfield_extract_insert_unit_defines.svh
// assertion macros for the bit-field unit
`ifndef BITFIELD_EXTRACT_INSERT_UNIT_DEFINES_SVH
`define BITFIELD_EXTRACT_INSERT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BFEIU_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("bit-field unit check failed");
`define BFEIU_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("bit-field unit check failed");
`else
`define BFEIU_ASSERT_IMP(label, a, b)
`define BFEIU_ASSERT_NEXT(label, a, b)
`endif

`endif

FILE: src/bfeiu_pkg.sv
// shared types, codes and the cycle table of the bit-field unit
package bfeiu_pkg;

  typedef enum logic [2:0] {
    OP_TST  = 3'd0,
    OP_EXTU = 3'd1,
    OP_CHG  = 3'd2,
    OP_EXTS = 3'd3,
    OP_CLR  = 3'd4,
    OP_FFO  = 3'd5,
    OP_SET  = 3'd6,
    OP_INS  = 3'd7
  } op_t;

  // access class: register, memory in four bytes, memory reaching the fifth byte
  typedef enum logic [1:0] {
    CLS_REG  = 2'd0,
    CLS_MEM4 = 2'd1,
    CLS_MEM5 = 2'd2
  } cls_t;

  typedef struct packed {
    op_t         op;
    logic        en;
    logic        mem;
    logic        x;
    logic [39:0] dd;
    logic [31:0] off;
    logic [31:0] ins;
    logic [31:0] window;   // field left-aligned at bit 31
    logic [31:0] topmask;  // top width bits set
    logic [5:0]  width;
    logic [4:0]  o;
    cls_t        cls;
  } s1_t;

  typedef struct packed {
    op_t         op;
    logic        en;
    logic        mem;
    logic        x;
    logic [39:0] dd;
    logic [31:0] off;
    logic [31:0] topmask;
    logic [31:0] nf;       // new field, left-aligned
    logic [31:0] ext;      // extracted field, zero or sign extended
    logic [5:0]  lz;
    logic [4:0]  o;
    cls_t        cls;
    logic        n;
    logic        z;
    logic        wr_dest;
    logic        wr_reg;
  } s2_t;

  function automatic logic [5:0] cycles(op_t op, cls_t cls);
    logic [5:0] c_reg;
    logic [5:0] c_m4;
    logic [5:0] c_m5;
    logic [5:0] r;
    unique case (op)
      OP_TST: begin
        c_reg = 6'd7;  c_m4 = 6'd12; c_m5 = 6'd16;
      end
      OP_EXTU, OP_EXTS: begin
        c_reg = 6'd8;  c_m4 = 6'd13; c_m5 = 6'd18;
      end
      OP_CHG, OP_CLR, OP_SET: begin
        c_reg = 6'd12; c_m4 = 6'd16; c_m5 = 6'd24;
      end
      OP_FFO: begin
        c_reg = 6'd18; c_m4 = 6'd24; c_m5 = 6'd32;
      end
      OP_INS: begin
        c_reg = 6'd10; c_m4 = 6'd15; c_m5 = 6'd21;
      end
    endcase
    unique case (cls)
      CLS_REG:  r = c_reg;
      CLS_MEM4: r = c_m4;
      default:  r = c_m5;
    endcase
    return r;
  endfunction

endpackage

FILE: src/bfeiu_if.sv
// word channels of the bit-field unit
interface bfeiu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic               mem_mode;
  logic [39:0]        dest_data;
  logic signed [31:0] field_offset;
  logic [4:0]         width_code;
  logic [31:0]        insert_value;
  logic               x_in;

  modport source (output valid, op, mem_mode, dest_data, field_offset, width_code,
                  insert_value, x_in, input ready);
  modport sink (input valid, op, mem_mode, dest_data, field_offset, width_code,
                insert_value, x_in, output ready);
endinterface

interface bfeiu_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] dest_out;
  logic        write_dest;
  logic [31:0] reg_result;
  logic        write_reg;
  logic [4:0]  ccr;
  logic [5:0]  cycle_count;
  logic        illegal;

  modport source (output valid, dest_out, write_dest, reg_result, write_reg, ccr,
                  cycle_count, illegal, input ready);
  modport sink (input valid, dest_out, write_dest, reg_result, write_reg, ccr,
                cycle_count, illegal, output ready);
endinterface

FILE: src/bfeiu_align.sv
// first stage: width decode and alignment of the field window
module bfeiu_align (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  bfeiu_in_if.sink        item,
  input  logic            ready_out,
  output logic            valid_out,
  output bfeiu_pkg::s1_t  data_out
);
  import bfeiu_pkg::*;

  logic        valid;
  logic [5:0]  width;
  logic [4:0]  o;
  logic [39:0] w40;
  logic [39:0] sh40;
  logic [6:0]  span;
  s1_t         nxt;

  assign item.ready = !valid || ready_out;
  assign valid_out  = valid;

  always_comb begin
    width = (item.width_code == 5'd0) ? 6'd32 : {1'b0, item.width_code};
    o     = item.mem_mode ? {2'b00, item.field_offset[2:0]} : item.field_offset[4:0];
    // register mode: pad below bit 0 so that nothing wraps in
    w40   = item.mem_mode ? item.dest_data : {item.dest_data[31:0], 8'h00};
    sh40  = w40 << o;
    span  = {2'b00, o} + {1'b0, width};

    nxt.op      = op_t'(item.op);
    nxt.en      = enable;
    nxt.mem     = item.mem_mode;
    nxt.x       = item.x_in;
    nxt.dd      = item.dest_data;
    nxt.off     = item.field_offset;
    nxt.ins     = item.insert_value;
    nxt.window  = sh40[39:8];
    nxt.topmask = ~(32'hFFFF_FFFF >> width);
    nxt.width   = width;
    nxt.o       = o;
    priority if (!item.mem_mode) begin
      nxt.cls = CLS_REG;
    end else if (span > 7'd32) begin
      nxt.cls = CLS_MEM5;
    end else begin
      nxt.cls = CLS_MEM4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      data_out <= nxt;
    end
  end

endmodule

FILE: src/bfeiu_field.sv
// second stage: field value, flags, new field and leading-zero search
module bfeiu_field (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  bfeiu_pkg::s1_t  data_in,
  output logic            ready_in,
  input  logic            ready_out,
  output logic            valid_out,
  output bfeiu_pkg::s2_t  data_out
);
  import bfeiu_pkg::*;

  logic               valid;
  logic [31:0]        fieldl;
  logic [31:0]        insl;
  logic [4:0]         shamt;
  logic signed [31:0] win_s;
  logic [31:0]        sext;
  logic [31:0]        fval;
  logic [5:0]         lz;
  s2_t                nxt;

  assign ready_in  = !valid || ready_out;
  assign valid_out = valid;

  always_comb begin
    fieldl = data_in.window & data_in.topmask;
    shamt  = 5'(6'd32 - data_in.width);
    fval   = fieldl >> shamt;
    win_s  = $signed(data_in.window);
    sext   = 32'(win_s >>> shamt);
    insl   = data_in.ins << shamt;

    // priority encoder, a zero field counts as its width
    lz = data_in.width;
    for (int i = 0; i < 32; i++) begin
      if (fieldl[i]) begin
        lz = 6'(31 - i);
      end
    end

    nxt.op      = data_in.op;
    nxt.en      = data_in.en;
    nxt.mem     = data_in.mem;
    nxt.x       = data_in.x;
    nxt.dd      = data_in.dd;
    nxt.off     = data_in.off;
    nxt.topmask = data_in.topmask;
    nxt.o       = data_in.o;
    nxt.cls     = data_in.cls;
    nxt.lz      = lz;
    nxt.ext     = (data_in.op == OP_EXTS) ? sext : fval;
    nxt.n       = data_in.window[31];
    nxt.z       = (fieldl == 32'd0);
    nxt.wr_dest = 1'b0;
    nxt.wr_reg  = 1'b0;
    nxt.nf      = fieldl;
    unique case (data_in.op)
      OP_TST: begin
      end
      OP_EXTU, OP_EXTS, OP_FFO: begin
        nxt.wr_reg = 1'b1;
      end
      OP_CHG: begin
        nxt.nf      = ~data_in.window & data_in.topmask;
        nxt.wr_dest = 1'b1;
      end
      OP_CLR: begin
        nxt.nf      = 32'd0;
        nxt.wr_dest = 1'b1;
      end
      OP_SET: begin
        nxt.nf      = data_in.topmask;
        nxt.wr_dest = 1'b1;
      end
      OP_INS: begin
        // flags follow the inserted value
        nxt.nf      = insl;
        nxt.n       = insl[31];
        nxt.z       = (insl == 32'd0);
        nxt.wr_dest = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
    if (valid_in && ready_in) begin
      data_out <= nxt;
    end
  end

endmodule

FILE: src/bfeiu_merge.sv
// third stage: merge of the new field, register result and output register
module bfeiu_merge (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  bfeiu_pkg::s2_t  data_in,
  output logic            ready_in,
  bfeiu_out_if.source     result
);
  import bfeiu_pkg::*;

  typedef struct packed {
    logic [39:0] dest_out;
    logic        write_dest;
    logic [31:0] reg_result;
    logic        write_reg;
    logic [4:0]  ccr;
    logic [5:0]  cycle_count;
    logic        illegal;
  } res_t;

  logic        valid;
  logic [39:0] m40;
  logic [39:0] n40;
  logic [39:0] dout;
  logic [31:0] r32;
  res_t        nxt;
  res_t        res;

  assign ready_in = !valid || result.ready;

  always_comb begin
    m40 = {data_in.topmask, 8'h00} >> data_in.o;
    n40 = {data_in.nf, 8'h00} >> data_in.o;
    // register mode drops what falls below bit 0 and keeps the top byte
    r32 = (data_in.dd[31:0] & ~m40[39:8]) | n40[39:8];
    priority if (!data_in.wr_dest) begin
      dout = data_in.dd;
    end else if (data_in.mem) begin
      dout = (data_in.dd & ~m40) | n40;
    end else begin
      dout = {data_in.dd[39:32], r32};
    end

    nxt.dest_out    = dout;
    nxt.write_dest  = data_in.wr_dest;
    nxt.write_reg   = data_in.wr_reg;
    nxt.ccr         = {data_in.x, data_in.n, data_in.z, 2'b00};
    nxt.cycle_count = cycles(data_in.op, data_in.cls);
    nxt.illegal     = 1'b0;
    unique case (data_in.op)
      OP_EXTU, OP_EXTS: nxt.reg_result = data_in.ext;
      OP_FFO:           nxt.reg_result = data_in.off + {26'd0, data_in.lz};
      default:          nxt.reg_result = 32'd0;
    endcase
    if (!data_in.en) begin
      nxt         = '0;
      nxt.illegal = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
    if (valid_in && ready_in) begin
      res <= nxt;
    end
  end

  assign result.valid       = valid;
  assign result.dest_out    = res.dest_out;
  assign result.write_dest  = res.write_dest;
  assign result.reg_result  = res.reg_result;
  assign result.write_reg   = res.write_reg;
  assign result.ccr         = res.ccr;
  assign result.cycle_count = res.cycle_count;
  assign result.illegal     = res.illegal;

endmodule

FILE: src/bitfield_extract_insert_unit.sv
// top level of the bit-field unit: enable register and three-stage pipeline
//
//   channel  dir  handshake      carries
//   item     in   valid/ready    op, mem_mode, dest_data, field_offset, width_code,
//                                insert_value, x_in
//   result   out  valid/ready    dest_out, write_dest, reg_result, write_reg, ccr,
//                                cycle_count, illegal
//   apb      in   psel/penable   bitfield_enable at byte address 0
//
// one word accepted per cycle while no stage stalls; a result passes the align, field and merge registers
// stages: window alignment, field and leading-zero search, merge and add
// each stage holds its word while the next is full; a stall loses nothing
// synchronous reset empties the pipeline and sets bitfield_enable to one
`include "bitfield_extract_insert_unit_defines.svh"

module bitfield_extract_insert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bfeiu_in_if.sink    item,
  bfeiu_out_if.source result
);
  import bfeiu_pkg::*;

  localparam logic REG_ENABLE = 1'b0;

  logic bitfield_enable;
  logic v1;
  logic v2;
  logic r2;
  logic r3;
  s1_t  d1;
  s2_t  d2;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, bitfield_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bitfield_enable <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_ENABLE) begin
      bitfield_enable <= pwdata[0];
    end
  end

  bfeiu_align u_align (
    .clk       (clk),
    .rst       (rst),
    .enable    (bitfield_enable),
    .item      (item),
    .ready_out (r2),
    .valid_out (v1),
    .data_out  (d1)
  );

  bfeiu_field u_field (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v1),
    .data_in   (d1),
    .ready_in  (r2),
    .ready_out (r3),
    .valid_out (v2),
    .data_out  (d2)
  );

  bfeiu_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v2),
    .data_in  (d2),
    .ready_in (r3),
    .result   (result)
  );

  // a disabled word carries nothing but its illegal flag
  `BFEIU_ASSERT_IMP(a_illegal_clean, result.valid && result.illegal,
    !result.write_dest && !result.write_reg && result.reg_result == 32'd0
    && result.dest_out == 40'd0 && result.cycle_count == 6'd0)
  // a legal word writes back to at most one place and reports a nonzero cycle_count from the table
  `BFEIU_ASSERT_IMP(a_one_target, result.valid && !result.illegal,
    !(result.write_dest && result.write_reg) && result.cycle_count >= 6'd7)
  // a stage that is stalled keeps its word
  `BFEIU_ASSERT_NEXT(a_stage2_hold, v2 && !r3, v2 && $stable(d2))

endmodule
